FILE: rtl/core/mieu_pkg.sv
// Shared types, opcodes and constants of the integer execute unit.
// No dependencies; imported by every module of the block.
package mieu_pkg;

	localparam int unsigned DATA_WORDS = 1024;
	localparam int unsigned DADDR_W = $clog2(DATA_WORDS);
	localparam logic [31:0] TEXT_BASE_RST = 32'h0040_0000;

	localparam logic [2:0] FLT_NONE  = 3'd0;
	localparam logic [2:0] FLT_OVF   = 3'd1;
	localparam logic [2:0] FLT_DIV0  = 3'd2;
	localparam logic [2:0] FLT_ALIGN = 3'd3;
	localparam logic [2:0] FLT_OPC   = 3'd4;

	localparam logic [5:0] OP_SPECIAL = 6'd0;
	localparam logic [5:0] OP_REGIMM  = 6'd1;
	localparam logic [5:0] OP_J       = 6'd2;
	localparam logic [5:0] OP_JAL     = 6'd3;
	localparam logic [5:0] OP_BEQ     = 6'd4;
	localparam logic [5:0] OP_BNE     = 6'd5;
	localparam logic [5:0] OP_BLEZ    = 6'd6;
	localparam logic [5:0] OP_BGTZ    = 6'd7;
	localparam logic [5:0] OP_ADDI    = 6'd8;
	localparam logic [5:0] OP_ADDIU   = 6'd9;
	localparam logic [5:0] OP_SLTI    = 6'd10;
	localparam logic [5:0] OP_ANDI    = 6'd12;
	localparam logic [5:0] OP_ORI     = 6'd13;
	localparam logic [5:0] OP_XORI    = 6'd14;
	localparam logic [5:0] OP_LUI     = 6'd15;
	localparam logic [5:0] OP_LB      = 6'd32;
	localparam logic [5:0] OP_LH      = 6'd33;
	localparam logic [5:0] OP_LW      = 6'd35;
	localparam logic [5:0] OP_LBU     = 6'd36;
	localparam logic [5:0] OP_LHU     = 6'd37;
	localparam logic [5:0] OP_SB      = 6'd40;
	localparam logic [5:0] OP_SH      = 6'd41;
	localparam logic [5:0] OP_SW      = 6'd43;

	localparam logic [5:0] FN_SLL     = 6'd0;
	localparam logic [5:0] FN_SRL     = 6'd2;
	localparam logic [5:0] FN_SRA     = 6'd3;
	localparam logic [5:0] FN_JR      = 6'd8;
	localparam logic [5:0] FN_JALR    = 6'd9;
	localparam logic [5:0] FN_SYSCALL = 6'd12;
	localparam logic [5:0] FN_MFHI    = 6'd16;
	localparam logic [5:0] FN_MTHI    = 6'd17;
	localparam logic [5:0] FN_MFLO    = 6'd18;
	localparam logic [5:0] FN_MTLO    = 6'd19;
	localparam logic [5:0] FN_MULT    = 6'd24;
	localparam logic [5:0] FN_MULTU   = 6'd25;
	localparam logic [5:0] FN_DIV     = 6'd26;
	localparam logic [5:0] FN_DIVU    = 6'd27;
	localparam logic [5:0] FN_ADD     = 6'd32;
	localparam logic [5:0] FN_ADDU    = 6'd33;
	localparam logic [5:0] FN_SUB     = 6'd34;
	localparam logic [5:0] FN_SUBU    = 6'd35;
	localparam logic [5:0] FN_AND     = 6'd36;
	localparam logic [5:0] FN_OR      = 6'd37;
	localparam logic [5:0] FN_XOR     = 6'd38;
	localparam logic [5:0] FN_NOR     = 6'd39;
	localparam logic [5:0] FN_SLT     = 6'd42;

	localparam logic [4:0] RT_BLTZ = 5'd0;
	localparam logic [4:0] RT_BGEZ = 5'd1;
	localparam logic [4:0] REG_RA  = 5'd31;

	typedef struct packed {
		logic accept;
		logic mem_rd;
		logic md_start;
		logic commit;
		logic clear;
	} cmd_t;

	typedef struct packed {
		logic need_mem;
		logic need_md;
		logic md_done;
		logic clr_last;
	} stat_t;

	typedef struct packed {
		logic start;
		logic div;
		logic sgn;
	} md_req_t;

endpackage

FILE: rtl/core/mieu_muldiv.sv
// Iterative multiply/divide unit: one shift-add or restore step per cycle.
// Depends on mieu_pkg.
module mieu_muldiv (
	input  logic              clk,
	input  logic              arst_n,
	input  mieu_pkg::md_req_t req,
	input  logic [31:0]       a,
	input  logic [31:0]       b,
	output logic [31:0]       hi,
	output logic [31:0]       lo,
	output logic              done
);
	import mieu_pkg::*;

	logic        busy_q, fix_q, done_q;
	logic [4:0]  cnt_q;
	logic [32:0] acc_q;
	logic [31:0] sh_q, mc_q, hi_q, lo_q;
	logic        neg_q, rneg_q, div_q;
	logic [32:0] sum, shl, diff;
	logic [63:0] prod, nprod;

	assign sum   = {1'b0, acc_q[31:0]} + (sh_q[0] ? {1'b0, mc_q} : 33'd0);
	assign shl   = {acc_q[31:0], sh_q[31]};
	assign diff  = shl - {1'b0, mc_q};
	assign prod  = {acc_q[31:0], sh_q};
	assign nprod = ~prod + 64'd1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			fix_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (req.start) begin
			busy_q <= 1'b1;
			fix_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + 5'd1;
			if (cnt_q == 5'd31) begin
				busy_q <= 1'b0;
				fix_q  <= 1'b1;
			end
		end else if (fix_q) begin
			fix_q  <= 1'b0;
			done_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			acc_q  <= '0;
			sh_q   <= (req.sgn && a[31]) ? (~a + 32'd1) : a;
			mc_q   <= (req.sgn && b[31]) ? (~b + 32'd1) : b;
			neg_q  <= req.sgn && (a[31] ^ b[31]);
			rneg_q <= req.sgn && req.div && a[31];
			div_q  <= req.div;
		end else if (busy_q) begin
			if (div_q) begin
				acc_q <= diff[32] ? shl : diff;
				sh_q  <= {sh_q[30:0], ~diff[32]};
			end else begin
				acc_q <= {1'b0, sum[32:1]};
				sh_q  <= {sum[0], sh_q[31:1]};
			end
		end else if (fix_q) begin
			if (div_q) begin
				lo_q <= neg_q ? (~sh_q + 32'd1) : sh_q;
				hi_q <= rneg_q ? (~acc_q[31:0] + 32'd1) : acc_q[31:0];
			end else begin
				lo_q <= neg_q ? nprod[31:0] : prod[31:0];
				hi_q <= neg_q ? nprod[63:32] : prod[63:32];
			end
		end
	end

	assign hi   = hi_q;
	assign lo   = lo_q;
	assign done = done_q;

endmodule

FILE: rtl/core/mieu_dp.sv
// Datapath: register file, HI/LO, PC, data memory, decode/execute and result register.
// Depends on mieu_pkg and mieu_muldiv.
module mieu_dp (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            cfg_wr_en,
	input  logic [31:0]     cfg_wr_data,
	input  logic [31:0]     instruction_word,
	input  mieu_pkg::cmd_t  cmd,
	output mieu_pkg::stat_t stat,
	output logic [31:0]     next_pc,
	output logic            writeback_valid,
	output logic [4:0]      writeback_index,
	output logic [31:0]     writeback_value,
	output logic            halted,
	output logic [2:0]      fault_code
);
	import mieu_pkg::*;

	logic [31:0] regs [32];
	logic [31:0] rv_q;
	logic [31:0] dmem [DATA_WORDS];
	logic [31:0] ir_q, a_q, b_q, mrd_q, pc_q, hi_q, lo_q;
	logic        halt_q;
	logic [DADDR_W-1:0] clr_q;

	logic [5:0]  op, fn;
	logic [4:0]  rs_in, rt_in, rt, rd, sa;
	logic [15:0] imm;
	logic [31:0] simm, pc4, btarget, addr, sum, dif, ldsh, lmask;
	logic [4:0]  lsh;
	logic [DADDR_W-1:0] widx;

	logic [31:0] npc, wb_val, hi_wd, lo_wd, st_word;
	logic [4:0]  wb_idx;
	logic [2:0]  fault;
	logic        wb_en, set_halt, hi_we, lo_we, is_mem, is_st, is_md;
	logic        wb_ok, mem_we;
	logic [DADDR_W-1:0] waddr;
	logic [31:0] wdata, md_hi, md_lo;
	logic        md_done;
	md_req_t     md_req;

	assign rs_in = instruction_word[25:21];
	assign rt_in = instruction_word[20:16];
	assign op    = ir_q[31:26];
	assign fn    = ir_q[5:0];
	assign rt    = ir_q[20:16];
	assign rd    = ir_q[15:11];
	assign sa    = ir_q[10:6];
	assign imm   = ir_q[15:0];
	assign simm  = {{16{imm[15]}}, imm};
	assign pc4   = pc_q + 32'd4;
	assign btarget = pc4 + {simm[29:0], 2'b00};
	assign addr  = a_q + simm;
	assign widx  = addr[DADDR_W+1:2];
	assign lsh   = {addr[1:0], 3'b000};
	assign ldsh  = mrd_q >> lsh;

	always_comb begin
		npc      = pc4;
		wb_en    = 1'b0;
		wb_idx   = rd;
		wb_val   = '0;
		fault    = FLT_NONE;
		set_halt = 1'b0;
		hi_we    = 1'b0;
		lo_we    = 1'b0;
		hi_wd    = a_q;
		lo_wd    = a_q;
		is_mem   = 1'b0;
		is_st    = 1'b0;
		is_md    = 1'b0;
		md_req.start = cmd.md_start;
		md_req.div = 1'b0;
		md_req.sgn = 1'b0;
		sum      = a_q + b_q;
		dif      = a_q - b_q;
		lmask    = 32'h0000_00FF << lsh;
		st_word  = b_q;
		unique case (op)
			OP_SPECIAL: begin
				unique case (fn)
					FN_SLL: begin wb_en = 1'b1; wb_val = b_q << sa; end
					FN_SRL: begin wb_en = 1'b1; wb_val = b_q >> sa; end
					FN_SRA: begin wb_en = 1'b1; wb_val = $unsigned($signed(b_q) >>> sa); end
					FN_JR: begin
						if (a_q[1:0] != 2'b00) fault = FLT_ALIGN;
						else npc = a_q;
					end
					FN_JALR: begin
						if (a_q[1:0] != 2'b00) fault = FLT_ALIGN;
						else begin
							npc = a_q;
							wb_en = 1'b1;
							wb_val = pc4;
						end
					end
					FN_SYSCALL: set_halt = 1'b1;
					FN_MFHI: begin wb_en = 1'b1; wb_val = hi_q; end
					FN_MTHI: hi_we = 1'b1;
					FN_MFLO: begin wb_en = 1'b1; wb_val = lo_q; end
					FN_MTLO: lo_we = 1'b1;
					FN_MULT: begin is_md = 1'b1; md_req.sgn = 1'b1; end
					FN_MULTU: is_md = 1'b1;
					FN_DIV: begin
						if (b_q == '0) fault = FLT_DIV0;
						else begin is_md = 1'b1; md_req.div = 1'b1; md_req.sgn = 1'b1; end
					end
					FN_DIVU: begin
						if (b_q == '0) fault = FLT_DIV0;
						else begin is_md = 1'b1; md_req.div = 1'b1; end
					end
					FN_ADD: begin
						if (((a_q ^ sum) & (b_q ^ sum)) >> 31 != 32'd0) fault = FLT_OVF;
						else begin wb_en = 1'b1; wb_val = sum; end
					end
					FN_ADDU: begin wb_en = 1'b1; wb_val = sum; end
					FN_SUB: begin
						if (((a_q ^ b_q) & (a_q ^ dif)) >> 31 != 32'd0) fault = FLT_OVF;
						else begin wb_en = 1'b1; wb_val = dif; end
					end
					FN_SUBU: begin wb_en = 1'b1; wb_val = dif; end
					FN_AND: begin wb_en = 1'b1; wb_val = a_q & b_q; end
					FN_OR:  begin wb_en = 1'b1; wb_val = a_q | b_q; end
					FN_XOR: begin wb_en = 1'b1; wb_val = a_q ^ b_q; end
					FN_NOR: begin wb_en = 1'b1; wb_val = ~(a_q | b_q); end
					FN_SLT: begin
						wb_en = 1'b1;
						wb_val = {31'd0, $signed(a_q) < $signed(b_q)};
					end
					default: fault = FLT_OPC;
				endcase
			end
			OP_REGIMM: begin
				if (rt == RT_BLTZ) begin
					if (a_q[31]) npc = btarget;
				end else if (rt == RT_BGEZ) begin
					if (!a_q[31]) npc = btarget;
				end else fault = FLT_OPC;
			end
			OP_J: npc = {pc4[31:28], ir_q[25:0], 2'b00};
			OP_JAL: begin
				npc = {pc4[31:28], ir_q[25:0], 2'b00};
				wb_en = 1'b1;
				wb_idx = REG_RA;
				wb_val = pc4;
			end
			OP_BEQ:  if (a_q == b_q) npc = btarget;
			OP_BNE:  if (a_q != b_q) npc = btarget;
			OP_BLEZ: if (a_q[31] || a_q == '0) npc = btarget;
			OP_BGTZ: if (!a_q[31] && a_q != '0) npc = btarget;
			OP_ADDI: begin
				wb_idx = rt;
				if (((a_q ^ addr) & (simm ^ addr)) >> 31 != 32'd0) fault = FLT_OVF;
				else begin wb_en = 1'b1; wb_val = addr; end
			end
			OP_ADDIU: begin wb_idx = rt; wb_en = 1'b1; wb_val = addr; end
			OP_SLTI: begin
				wb_idx = rt;
				wb_en = 1'b1;
				wb_val = {31'd0, $signed(a_q) < $signed(simm)};
			end
			OP_ANDI: begin wb_idx = rt; wb_en = 1'b1; wb_val = a_q & {16'd0, imm}; end
			OP_ORI:  begin wb_idx = rt; wb_en = 1'b1; wb_val = a_q | {16'd0, imm}; end
			OP_XORI: begin wb_idx = rt; wb_en = 1'b1; wb_val = a_q ^ {16'd0, imm}; end
			OP_LUI:  begin wb_idx = rt; wb_en = 1'b1; wb_val = {imm, 16'd0}; end
			OP_LB, OP_LBU: begin
				wb_idx = rt;
				is_mem = 1'b1;
				wb_en = 1'b1;
				wb_val = {{24{ldsh[7] & (op == OP_LB)}}, ldsh[7:0]};
			end
			OP_LH, OP_LHU: begin
				wb_idx = rt;
				if (addr[0]) fault = FLT_ALIGN;
				else begin
					is_mem = 1'b1;
					wb_en = 1'b1;
					wb_val = {{16{ldsh[15] & (op == OP_LH)}}, ldsh[15:0]};
				end
			end
			OP_LW: begin
				wb_idx = rt;
				if (addr[1:0] != 2'b00) fault = FLT_ALIGN;
				else begin is_mem = 1'b1; wb_en = 1'b1; wb_val = mrd_q; end
			end
			OP_SB: begin
				is_mem = 1'b1;
				is_st = 1'b1;
				st_word = (mrd_q & ~lmask) | ({24'd0, b_q[7:0]} << lsh);
			end
			OP_SH: begin
				lmask = 32'h0000_FFFF << lsh;
				if (addr[0]) fault = FLT_ALIGN;
				else begin
					is_mem = 1'b1;
					is_st = 1'b1;
					st_word = (mrd_q & ~lmask) | ({16'd0, b_q[15:0]} << lsh);
				end
			end
			OP_SW: begin
				if (addr[1:0] != 2'b00) fault = FLT_ALIGN;
				else begin is_mem = 1'b1; is_st = 1'b1; end
			end
			default: fault = FLT_OPC;
		endcase
		if (fault != FLT_NONE) npc = pc4;
	end

	assign wb_ok = wb_en && (wb_idx != 5'd0) && (fault == FLT_NONE) && !halt_q;

	assign stat.need_mem = is_mem && !halt_q;
	assign stat.need_md  = is_md && !halt_q;
	assign stat.md_done  = md_done;
	assign stat.clr_last = (clr_q == DADDR_W'(DATA_WORDS - 1));

	mieu_muldiv u_md (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (md_req),
		.a      (a_q),
		.b      (b_q),
		.hi     (md_hi),
		.lo     (md_lo),
		.done   (md_done)
	);

	// register file: 2 registered reads at accept, 1 write at commit
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			ir_q <= instruction_word;
			a_q  <= rv_q[rs_in] ? regs[rs_in] : '0;
			b_q  <= rv_q[rt_in] ? regs[rt_in] : '0;
		end
		if (cmd.commit && wb_ok) regs[wb_idx] <= wb_val;
	end

	assign mem_we = cmd.clear || (cmd.commit && is_st && !halt_q);
	assign waddr  = cmd.clear ? clr_q : widx;
	assign wdata  = cmd.clear ? '0 : st_word;

	always_ff @(posedge clk) begin
		if (mem_we) dmem[waddr] <= wdata;
		if (cmd.mem_rd) mrd_q <= dmem[widx];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rv_q   <= '0;
			pc_q   <= TEXT_BASE_RST;
			hi_q   <= '0;
			lo_q   <= '0;
			halt_q <= 1'b0;
			clr_q  <= '0;
		end else begin
			if (cmd.clear) clr_q <= clr_q + 1'b1;
			if (cfg_wr_en) pc_q <= cfg_wr_data;
			else if (cmd.commit && !halt_q) begin
				pc_q <= npc;
				if (wb_ok) rv_q[wb_idx] <= 1'b1;
				if (set_halt) halt_q <= 1'b1;
				if (is_md) begin
					hi_q <= md_hi;
					lo_q <= md_lo;
				end
				if (hi_we) hi_q <= hi_wd;
				if (lo_we) lo_q <= lo_wd;
			end
		end
	end

	// result register
	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			next_pc         <= halt_q ? pc_q : npc;
			writeback_valid <= wb_ok;
			writeback_index <= wb_ok ? wb_idx : 5'd0;
			writeback_value <= wb_ok ? wb_val : 32'd0;
			halted          <= halt_q || set_halt;
			fault_code      <= halt_q ? FLT_NONE : fault;
		end
	end

endmodule

FILE: rtl/core/mieu_ctrl.sv
// Sequencer: memory clear after reset, accept, execute, memory/muldiv wait, commit.
// Depends on mieu_pkg.
module mieu_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_stall,
	output logic            out_valid,
	input  logic            out_stall,
	input  mieu_pkg::stat_t stat,
	output mieu_pkg::cmd_t  cmd
);
	import mieu_pkg::*;

	localparam logic [2:0] ST_CLEAR = 3'd0;
	localparam logic [2:0] ST_IDLE  = 3'd1;
	localparam logic [2:0] ST_EXEC  = 3'd2;
	localparam logic [2:0] ST_MEM   = 3'd3;
	localparam logic [2:0] ST_MD    = 3'd4;

	logic [2:0] state_q, state_d;
	logic       ov_q, out_free;

	assign out_free = !ov_q || !out_stall;

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			ST_CLEAR: begin
				cmd.clear = 1'b1;
				if (stat.clr_last) state_d = ST_IDLE;
			end
			ST_IDLE: begin
				if (in_valid) begin
					cmd.accept = 1'b1;
					state_d = ST_EXEC;
				end
			end
			ST_EXEC: begin
				if (stat.need_mem) begin
					cmd.mem_rd = 1'b1;
					state_d = ST_MEM;
				end else if (stat.need_md) begin
					cmd.md_start = 1'b1;
					state_d = ST_MD;
				end else if (out_free) begin
					cmd.commit = 1'b1;
					state_d = ST_IDLE;
				end
			end
			ST_MEM: begin
				if (out_free) begin
					cmd.commit = 1'b1;
					state_d = ST_IDLE;
				end
			end
			ST_MD: begin
				if (stat.md_done && out_free) begin
					cmd.commit = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			ov_q    <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.commit) ov_q <= 1'b1;
			else if (!out_stall) ov_q <= 1'b0;
		end
	end

	assign in_stall  = (state_q != ST_IDLE);
	assign out_valid = ov_q;

endmodule

FILE: rtl/core/mips_integer_execute_unit.sv
// Top level of the MIPS integer execute unit: sequencer plus datapath.
// Depends on mieu_pkg, mieu_ctrl, mieu_dp (and mieu_muldiv below it).
//
//  channel | signals                              | dir
//  cfg     | cfg_wr_en, cfg_wr_data (text_base)   | in
//  in      | in_valid, in_stall, instruction_word | in beat
//  out     | out_valid, out_stall, result fields  | out beat
//
// ALU, branch and jump commit from the execute state; loads and stores pass a
// memory state (registered memory read); multiply and divide wait in a state
// for the iterative unit (one step per cycle). After reset the data memory is
// swept to zero, DATA_WORDS (1024) words at one per cycle, with in_stall high.
// A held result beat does not block the next accept; commit waits for it.
module mips_integer_execute_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wr_en,
	input  logic [31:0] cfg_wr_data,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [31:0] instruction_word,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [31:0] next_pc,
	output logic        writeback_valid,
	output logic [4:0]  writeback_index,
	output logic [31:0] writeback_value,
	output logic        halted,
	output logic [2:0]  fault_code
);
	import mieu_pkg::*;

	cmd_t  cmd;
	stat_t stat;

	mieu_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.stat      (stat),
		.cmd       (cmd)
	);

	mieu_dp u_dp (
		.clk              (clk),
		.arst_n           (arst_n),
		.cfg_wr_en        (cfg_wr_en),
		.cfg_wr_data      (cfg_wr_data),
		.instruction_word (instruction_word),
		.cmd              (cmd),
		.stat             (stat),
		.next_pc          (next_pc),
		.writeback_valid  (writeback_valid),
		.writeback_index  (writeback_index),
		.writeback_value  (writeback_value),
		.halted           (halted),
		.fault_code       (fault_code)
	);

`ifndef SYNTHESIS
	a_clear_blocks_input: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.clear |-> in_stall)
		else $error("input accepted during memory clear");
	a_commit_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit |-> !(out_valid && out_stall))
		else $error("commit over a held result");
	a_cmd_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(cmd))
		else $error("conflicting commands");
	a_fault_no_wb: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && fault_code != FLT_NONE |-> !writeback_valid)
		else $error("register written on fault");
`endif

endmodule
